@@ rtl/oal_pkg.sv @@
// Shared types and constants for the ordered array list unit.
`default_nettype none

package oal_pkg;

    // Field widths fixed by the word formats
    localparam int OP_W    = 3;
    localparam int POS_W   = 6;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 6;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } oal_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] item_value;
        logic                    item_valid;
        logic                    last;
    } oal_out_t;

endpackage

`default_nettype wire

@@ rtl/oal_ram.sv @@
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module oal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port: data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/ordered_array_list_unit.sv @@
// Ordered array list unit: sequencer around a single element RAM.
//
// Keeps up to SLOTS-1 signed 32-bit elements at positions 1..count of one
// simple dual-port RAM (one write and one registered read per cycle). One
// input word is taken at a time. Clear, append, update and any failing or
// unused operation give one result word from the decode state once the
// output register is free. Insert moves the entries from the tail down to
// the given position up by one, one entry per cycle. Dump streams one
// element per cycle through the RAM read port while the output side keeps
// ready high; an empty dump gives a single word with item_valid low. The
// output word sits in a register, so the next input word is taken while a
// result still waits. The RAM contents need no reset: only written entries
// are ever read.
`default_nettype none

module ordered_array_list_unit
    import oal_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire oal_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output oal_out_t      out_data
);

    localparam int IW = $clog2(SLOTS);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT,
        S_PUT,
        S_DUMP
    } state_t;

    state_t                  state_reg, state_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IW-1:0]           idx_reg, idx_next;
    logic [IW-1:0]           rd_idx_reg, rd_idx_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic                    issue_done_reg, issue_done_next;
    logic                    out_valid_reg, out_valid_next;
    oal_out_t                out_data_reg, out_data_next;

    logic                    ram_we;
    logic [IW-1:0]           ram_waddr;
    logic [VAL_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [IW-1:0]           ram_raddr;
    logic [VAL_W-1:0]        ram_rdata;

    logic                    out_free;
    logic                    full;
    logic                    bad_pos;
    logic [IW-1:0]           cnt_idx;
    logic [IW-1:0]           pos_idx;
    logic                    consume;
    logic                    issue;

    oal_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Status decode; count stays below SLOTS, so its low bits index the RAM
    assign out_free = !out_valid_reg || out_ready;
    assign full     = (count_reg >= CAP);
    assign bad_pos  = (pos_reg == '0) || (pos_reg > count_reg);
    assign cnt_idx  = count_reg[IW-1:0];
    assign pos_idx  = pos_reg[IW-1:0];

    // Dump read pipeline: issue a read when none is pending or the pending word leaves
    assign consume = (state_reg == S_DUMP) && rd_pend_reg && out_free;
    assign issue   = !issue_done_reg && (!rd_pend_reg || consume);

    // Next-state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        rd_idx_next     = rd_idx_reg;
        rd_pend_next    = rd_pend_reg;
        issue_done_next = issue_done_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = val_reg;
        ram_re          = 1'b0;
        ram_raddr       = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                // Latch the input word
                if (in_valid)
                begin
                    op_next    = in_data.op;
                    pos_next   = in_data.position;
                    val_next   = in_data.value;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                if (out_free)
                begin
                    // Default single result word; paths below adjust it
                    out_data_next.status     = ST_OK;
                    out_data_next.count      = count_reg;
                    out_data_next.item_value = '0;
                    out_data_next.item_valid = 1'b0;
                    out_data_next.last       = 1'b1;
                    out_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                    case (op_reg)
                        OP_CLEAR:
                        begin
                            count_next          = '0;
                            out_data_next.count = '0;
                        end
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                out_data_next.status = ST_FULL;
                            end
                            else
                            begin
                                ram_we              = 1'b1;
                                ram_waddr           = cnt_idx + IW'(1);
                                count_next          = count_reg + CNT_W'(1);
                                out_data_next.count = count_reg + CNT_W'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            if (full)
                            begin
                                out_data_next.status = ST_FULL;
                            end
                            else if (bad_pos)
                            begin
                                out_data_next.status = ST_BADPOS;
                            end
                            else
                            begin
                                // Start the shift at the tail
                                out_valid_next  = out_valid_reg && !out_ready;
                                idx_next        = cnt_idx;
                                rd_pend_next    = 1'b0;
                                issue_done_next = 1'b0;
                                state_next      = S_SHIFT;
                            end
                        end
                        OP_UPDATE:
                        begin
                            if (bad_pos)
                            begin
                                out_data_next.status = ST_BADPOS;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = pos_idx;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (count_reg != '0)
                            begin
                                // Stream from position 1
                                out_valid_next  = out_valid_reg && !out_ready;
                                idx_next        = IW'(1);
                                rd_pend_next    = 1'b0;
                                issue_done_next = 1'b0;
                                state_next      = S_DUMP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                // Write back the entry read last cycle one slot higher
                if (rd_pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_idx_reg + IW'(1);
                    ram_wdata = ram_rdata;
                end
                // Read the next entry down
                if (!issue_done_reg)
                begin
                    ram_re      = 1'b1;
                    rd_idx_next = idx_reg;
                    if (idx_reg == pos_idx)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg - IW'(1);
                    end
                end
                rd_pend_next = !issue_done_reg;
                if (issue_done_reg && !rd_pend_reg)
                begin
                    state_next = S_PUT;
                end
            end

            S_PUT:
            begin
                // Drop the new value into the freed slot and report
                if (out_free)
                begin
                    ram_we                   = 1'b1;
                    ram_waddr                = pos_idx;
                    count_next               = count_reg + CNT_W'(1);
                    out_data_next.status     = ST_OK;
                    out_data_next.count      = count_reg + CNT_W'(1);
                    out_data_next.item_value = '0;
                    out_data_next.item_valid = 1'b0;
                    out_data_next.last       = 1'b1;
                    out_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            S_DUMP:
            begin
                // Hand the pending element to the output register
                if (consume)
                begin
                    out_data_next.status     = ST_OK;
                    out_data_next.count      = count_reg;
                    out_data_next.item_value = ram_rdata;
                    out_data_next.item_valid = 1'b1;
                    out_data_next.last       = (rd_idx_reg == cnt_idx);
                    out_valid_next           = 1'b1;
                    if (issue_done_reg && !issue)
                    begin
                        state_next = S_IDLE;
                    end
                end
                // Advance the read pointer
                if (issue)
                begin
                    ram_re      = 1'b1;
                    rd_idx_next = idx_reg;
                    if (idx_reg == cnt_idx)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
                rd_pend_next = issue || (rd_pend_reg && !consume);
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            rd_pend_reg    <= 1'b0;
            issue_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_pend_reg    <= rd_pend_next;
            issue_done_reg <= issue_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        rd_idx_reg   <= rd_idx_next;
        out_data_reg <= out_data_next;
    end

    // Count never passes capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("element count above capacity");

    // Shift never writes the entry it reads in the same cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("RAM read and write hit the same entry");

    // A dumped element only comes from a non-empty list
    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.item_valid) |-> (out_data_reg.count != '0))
        else $error("dump element with empty list");

    // No read in flight when a new input word can be taken
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !rd_pend_reg)
        else $error("read pending while idle");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the ordered array list unit: directed table, then random words.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import oal_pkg::*;

    localparam int SLOTS        = 64;
    localparam int CAPACITY     = SLOTS - 1;
    localparam int WORDS_PER_PHASE = 50;
    localparam int DRAIN_CYCLES = 160;
    localparam int HOLD_CYCLES  = 400;
    localparam int PRINT_CAP    = 60;

    typedef struct {
        oal_in_t  word;
        bit       typed;
        oal_out_t want;
    } table_row_t;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    oal_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    oal_out_t out_data;

    // Shadow list: positions 1..list_len of list_elems are live
    logic signed [VAL_W-1:0] list_elems [0:SLOTS-1];
    int unsigned             list_len;
    oal_out_t                pending_results [$];

    table_row_t directed_rows [$];
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_request = 0;
    int         hold_left = 0;
    int         mismatches = 0;
    int         fill_goal = CAPACITY;
    int         send_pcts [4] = '{0, 46, 0, 38};
    int         recv_pcts [4] = '{0, 0, 46, 38};

    ordered_array_list_unit #(
        .SLOTS(SLOTS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // Free-running clock, 2 ns period
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Apply one list operation to the shadow list and queue the words it returns
    task automatic apply_list_op(input oal_in_t w);
        oal_out_t    r;
        int unsigned k;
        r      = '0;
        r.last = 1'b1;
        case (w.op)
            OP_CLEAR:
                list_len = 0;
            OP_APPEND:
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    list_len++;
                    list_elems[list_len] = w.value;
                end
            OP_INSERT:
                // full is checked ahead of the position
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else if (w.position < 1 || w.position > list_len)
                    r.status = ST_BADPOS;
                else
                begin
                    for (k = list_len; k >= w.position; k--)
                        list_elems[k + 1] = list_elems[k];
                    list_elems[w.position] = w.value;
                    list_len++;
                end
            OP_UPDATE:
                if (w.position < 1 || w.position > list_len)
                    r.status = ST_BADPOS;
                else
                    list_elems[w.position] = w.value;
            OP_DUMP:
                if (list_len != 0)
                begin
                    for (k = 1; k <= list_len; k++)
                    begin
                        r.count      = CNT_W'(list_len);
                        r.item_value = list_elems[k];
                        r.item_valid = 1'b1;
                        r.last       = (k == list_len);
                        pending_results.push_back(r);
                    end
                    return;
                end
            default:
                ;
        endcase
        r.count = CNT_W'(list_len);
        pending_results.push_back(r);
    endtask

    // Offer one input word; entered and left at a falling edge
    task automatic send_word(input oal_in_t w, input bit typed, input oal_out_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_list_op(w);
        // typed rows carry their own single-word expectation
        if (typed)
        begin
            void'(pending_results.pop_back());
            pending_results.push_back(want);
        end
        @(negedge clk);
    endtask

    function automatic table_row_t mk_row(input logic [OP_W-1:0] op,
                                          input logic [POS_W-1:0] pos,
                                          input logic [VAL_W-1:0] val,
                                          input bit typed,
                                          input logic [STAT_W-1:0] st,
                                          input logic [CNT_W-1:0] cnt,
                                          input logic [VAL_W-1:0] item,
                                          input logic item_vld);
        table_row_t row;
        row.word.op          = op;
        row.word.position    = pos;
        row.word.value       = val;
        row.typed            = typed;
        row.want.status      = st;
        row.want.count       = cnt;
        row.want.item_value  = item;
        row.want.item_valid  = item_vld;
        row.want.last        = 1'b1;
        return row;
    endfunction

    // Pick the next random word: fill toward a goal, then clear and pick a new goal
    task automatic pick_random_word(output oal_in_t w);
        int unsigned r;
        w.value = $urandom;
        if (list_len != 0 && $urandom_range(0, 99) < 80)
            w.position = POS_W'($urandom_range(1, list_len));
        else
            w.position = POS_W'($urandom_range(0, 63));
        r = $urandom_range(0, 99);
        if (list_len >= fill_goal && r < 12)
        begin
            w.op      = OP_CLEAR;
            fill_goal = ($urandom_range(0, 3) == 0) ? CAPACITY : $urandom_range(1, 12);
        end
        else if (r < 40)
            w.op = OP_APPEND;
        else if (r < 65)
            w.op = OP_INSERT;
        else if (r < 80)
            w.op = OP_UPDATE;
        else if (r < 92)
            w.op = OP_DUMP;
        else
            w.op = OP_W'($urandom_range(5, 7));
    endtask

    // Drive out_ready: long hold-off on request, otherwise random stalls
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        oal_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected word %h", out_data));
            else
            begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              out_data.status, want.status));
                if (out_data.count !== want.count)
                    report_mismatch($sformatf("count got %0d expected %0d",
                                              out_data.count, want.count));
                if (out_data.item_value !== want.item_value)
                    report_mismatch($sformatf("item_value got %h expected %h",
                                              out_data.item_value, want.item_value));
                if (out_data.item_valid !== want.item_valid)
                    report_mismatch($sformatf("item_valid got %b expected %b",
                                              out_data.item_valid, want.item_valid));
                if (out_data.last !== want.last)
                    report_mismatch($sformatf("last got %b expected %b",
                                              out_data.last, want.last));
            end
        end
    end

    // Stop a hung run
    initial
    begin
        #1000000;
        $display("ordered_array_list_unit test failed");
        $finish;
    end

    // Main sequence
    initial
    begin
        oal_in_t  w;
        oal_out_t none;
        none     = '0;
        list_len = 0;

        // Directed table: dump after reset, empty insert, extremes, bad positions
        directed_rows.push_back(mk_row(OP_DUMP,   6'd0,  32'h0,        1, ST_OK,     6'd0, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_INSERT, 6'd1,  32'h5,        1, ST_BADPOS, 6'd0, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_UPDATE, 6'd1,  32'h5,        1, ST_BADPOS, 6'd0, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_APPEND, 6'd0,  32'h7FFFFFFF, 1, ST_OK,     6'd1, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_APPEND, 6'd63, 32'h80000000, 1, ST_OK,     6'd2, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_APPEND, 6'd0,  32'h0,        1, ST_OK,     6'd3, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_APPEND, 6'd0,  32'hFFFFFFFF, 1, ST_OK,     6'd4, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_INSERT, 6'd1,  32'h12345678, 1, ST_OK,     6'd5, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_INSERT, 6'd5,  32'hA5A5A5A5, 1, ST_OK,     6'd6, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_INSERT, 6'd3,  32'h5A5A5A5A, 1, ST_OK,     6'd7, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_INSERT, 6'd0,  32'h1,        1, ST_BADPOS, 6'd7, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_INSERT, 6'd8,  32'h2,        1, ST_BADPOS, 6'd7, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_INSERT, 6'd63, 32'h3,        1, ST_BADPOS, 6'd7, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_UPDATE, 6'd7,  32'h0F0F0F0F, 1, ST_OK,     6'd7, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_UPDATE, 6'd1,  32'hF0F0F0F0, 1, ST_OK,     6'd7, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_UPDATE, 6'd0,  32'h4,        1, ST_BADPOS, 6'd7, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_UPDATE, 6'd8,  32'h5,        1, ST_BADPOS, 6'd7, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_DUMP,   6'd0,  32'h0,        0, ST_OK,     6'd0, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(3'd5,      6'd63, 32'hFFFFFFFF, 1, ST_OK,     6'd7, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(3'd6,      6'd21, 32'h6,        1, ST_OK,     6'd7, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(3'd7,      6'd42, 32'h7,        1, ST_OK,     6'd7, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_CLEAR,  6'd0,  32'h0,        1, ST_OK,     6'd0, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_DUMP,   6'd0,  32'h0,        1, ST_OK,     6'd0, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_APPEND, 6'd0,  32'h13579BDF, 1, ST_OK,     6'd1, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(OP_DUMP,   6'd0,  32'h0,        1, ST_OK,     6'd1,
                                       32'h13579BDF, 1'b1));

        // Hold reset, then release it on a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

        // Random words in four idling phases; the first opens with a long output hold-off
        hold_request = HOLD_CYCLES;
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = send_pcts[ph];
            recv_stall_pct = recv_pcts[ph];
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                pick_random_word(w);
                send_word(w, 1'b0, none);
            end
        end
        in_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("ordered_array_list_unit test passed");
        else
            $display("ordered_array_list_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire
